// ===== hdl/dlle_pkg.sv =====
// ----------------------------------------------------------------------------
// dlle_pkg : shared types and constants for the ordered list engine
// Command and status codes, cell control word and controller states.
// ----------------------------------------------------------------------------
package dlle_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int POS_W          = 13;

  typedef enum logic [3:0] {
    OP_HEAD_ADD  = 4'd0,
    OP_TAIL_ADD  = 4'd1,
    OP_INSERT_AT = 4'd2,
    OP_HEAD_DEL  = 4'd3,
    OP_TAIL_DEL  = 4'd4,
    OP_DEL_AT    = 4'd5,
    OP_MODIFY    = 4'd6,
    OP_READ_AT   = 4'd7,
    OP_FIND      = 4'd8,
    OP_DEL_VALUE = 4'd9,
    OP_CLEAR     = 4'd10
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CM_HOLD = 2'd0,
    CM_INS  = 2'd1,
    CM_DEL  = 2'd2,
    CM_MOD  = 2'd3
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t       mode;
    logic [POS_W-1:0] k;
  } cell_ctrl_t;

  typedef enum logic {
    FS_IDLE = 1'b0,
    FS_SCAN = 1'b1
  } fsm_t;

endpackage

// ===== hdl/dlle_cell.sv =====
// ----------------------------------------------------------------------------
// dlle_cell : one list position
// Holds the word at its position; shifts in from either neighbour on
// insert or delete, loads on write, flags a key match.
// ----------------------------------------------------------------------------
module dlle_cell #(
  parameter int DATA_WIDTH = dlle_pkg::DATA_WIDTH_DEF,
  parameter int IDX        = 0
) (
  input  logic                    clk,
  input  dlle_pkg::cell_ctrl_t    ctrl,
  input  logic [DATA_WIDTH-1:0]   wdata,
  input  logic [DATA_WIDTH-1:0]   key,
  input  logic [DATA_WIDTH-1:0]   left_val,
  input  logic [DATA_WIDTH-1:0]   right_val,
  output logic [DATA_WIDTH-1:0]   val,
  output logic                    hit
);
  import dlle_pkg::*;

  localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

  always_ff @(posedge clk) begin
    case (ctrl.mode)
      CM_INS: begin
        if (MY_POS == ctrl.k) begin
          val <= wdata;
        end else if (MY_POS > ctrl.k) begin
          val <= left_val;
        end
      end
      CM_DEL: begin
        if (MY_POS >= ctrl.k) begin
          val <= right_val;
        end
      end
      CM_MOD: begin
        if (MY_POS == ctrl.k) begin
          val <= wdata;
        end
      end
      default: ;
    endcase
  end

  assign hit = (val == key);

endmodule

// ===== hdl/doubly_linked_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// doubly_linked_list_engine_unit : ordered list of signed words
// Row of position cells with a controller for commands and value scans.
//
// channel | dir | beat contents
// s_axis  | in  | op, index, value, match_value
// m_axis  | out | status, data, position, count
//
// Positional commands are carried out in the cycle that accepts them, with the result registered for the output beat.
// Modify, find and delete-by-value scan one position a cycle, a rate set by
// the single match-select port on the cell row.
// rst empties the list at once; no clearing pass.
// A stalled output beat holds; a new beat is taken as the held one leaves.
// ----------------------------------------------------------------------------
module doubly_linked_list_engine_unit #(
  parameter int CAPACITY   = dlle_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = dlle_pkg::DATA_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // op[3:0] index[9:4] value[41:10] match_value[73:42]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // status[1:0] data[33:2] position[40:34] count[47:41]
);
  import dlle_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  fsm_t state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] scan, scan_next;
  op_t              sop;
  logic [DATA_WIDTH-1:0] key, wreg;

  logic [DATA_WIDTH-1:0] cval [CAPACITY];
  logic [CAPACITY-1:0]   hit;
  cell_ctrl_t            ctrl;
  logic [DATA_WIDTH-1:0] wdata;

  logic [1:0]  res_status;
  logic [31:0] res_data;
  logic [6:0]  res_pos;
  logic [6:0]  res_count;
  logic        load_res;

  op_t         in_op;
  logic [5:0]  in_idx;
  logic signed [31:0] in_val, in_match;
  logic [DATA_WIDTH-1:0] w_val, w_match;
  logic        acc, idx_ok, full, hit_now, at_end;
  logic [DATA_WIDTH-1:0] rd_word;

  assign in_op    = op_t'(s_axis_tdata[3:0]);
  assign in_idx   = s_axis_tdata[9:4];
  assign in_val   = s_axis_tdata[41:10];
  assign in_match = s_axis_tdata[73:42];
  assign w_val    = DATA_WIDTH'(in_val);
  assign w_match  = DATA_WIDTH'(in_match);

  assign s_axis_tready = (state == FS_IDLE) && (!m_axis_tvalid || m_axis_tready);
  assign acc    = s_axis_tvalid && s_axis_tready;
  assign idx_ok = POS_W'(in_idx) < POS_W'(count);
  assign full   = count >= CNT_W'(CAPACITY);
  assign at_end = scan >= count;
  assign hit_now = hit[IW'(scan)];
  assign rd_word = cval[IW'(in_idx)];

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [DATA_WIDTH-1:0] lv, rv;
      if (g == 0) begin : g_l0
        assign lv = '0;
      end else begin : g_ln
        assign lv = cval[g-1];
      end
      if (g == CAPACITY - 1) begin : g_r0
        assign rv = '0;
      end else begin : g_rn
        assign rv = cval[g+1];
      end
      dlle_cell #(.DATA_WIDTH(DATA_WIDTH), .IDX(g)) u_cell (
        .clk(clk), .ctrl(ctrl), .wdata(wdata), .key(key),
        .left_val(lv), .right_val(rv), .val(cval[g]), .hit(hit[g])
      );
    end
  endgenerate

  always_comb begin
    state_next = state;
    case (state)
      FS_IDLE: begin
        if (acc && (in_op == OP_MODIFY || in_op == OP_FIND || in_op == OP_DEL_VALUE)) begin
          state_next = FS_SCAN;
        end
      end
      FS_SCAN: begin
        if (at_end || hit_now) begin
          state_next = FS_IDLE;
        end
      end
      default: state_next = FS_IDLE;
    endcase
  end

  always_comb begin
    ctrl       = '{mode: CM_HOLD, k: '0};
    wdata      = w_val;
    count_next = count;
    scan_next  = scan;
    load_res   = 1'b0;
    res_status = ST_OK;
    res_data   = '0;
    res_pos    = '0;
    case (state)
      FS_IDLE: begin
        scan_next = '0;
        if (acc) begin
          load_res = 1'b1;
          case (in_op)
            OP_HEAD_ADD, OP_TAIL_ADD: begin
              if (full) begin
                res_status = ST_FULL;
              end else begin
                ctrl.mode  = CM_INS;
                ctrl.k     = (in_op == OP_HEAD_ADD) ? '0 : POS_W'(count);
                count_next = count + 1'b1;
              end
            end
            OP_INSERT_AT: begin
              if (!idx_ok) begin
                res_status = ST_RANGE;
              end else if (full) begin
                res_status = ST_FULL;
              end else begin
                ctrl.mode  = CM_INS;
                ctrl.k     = POS_W'(in_idx);
                count_next = count + 1'b1;
              end
            end
            OP_HEAD_DEL, OP_TAIL_DEL: begin
              if (count == '0) begin
                res_status = ST_RANGE;
              end else begin
                ctrl.mode  = CM_DEL;
                ctrl.k     = (in_op == OP_HEAD_DEL) ? '0 : POS_W'(count - 1'b1);
                count_next = count - 1'b1;
              end
            end
            OP_DEL_AT: begin
              if (!idx_ok) begin
                res_status = ST_RANGE;
              end else begin
                ctrl.mode  = CM_DEL;
                ctrl.k     = POS_W'(in_idx);
                count_next = count - 1'b1;
              end
            end
            OP_READ_AT: begin
              if (!idx_ok) begin
                res_status = ST_RANGE;
              end else begin
                res_data = 32'($signed(rd_word));
              end
            end
            OP_MODIFY, OP_FIND, OP_DEL_VALUE: load_res = 1'b0;
            OP_CLEAR: count_next = '0;
            default: ;
          endcase
        end
      end
      FS_SCAN: begin
        wdata = wreg;
        if (at_end) begin
          load_res   = 1'b1;
          res_status = ST_MISS;
        end else if (hit_now) begin
          load_res = 1'b1;
          case (sop)
            OP_FIND: res_pos = 7'(scan);
            OP_MODIFY: begin
              ctrl.mode = CM_MOD;
              ctrl.k    = POS_W'(scan);
            end
            default: begin
              ctrl.mode  = CM_DEL;
              ctrl.k     = POS_W'(scan);
              count_next = count - 1'b1;
            end
          endcase
        end else begin
          scan_next = scan + 1'b1;
        end
      end
      default: ;
    endcase
    res_count = 7'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= FS_IDLE;
      count         <= '0;
      scan          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      scan  <= scan_next;
      if (load_res) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      sop  <= in_op;
      wreg <= w_val;
      key  <= (in_op == OP_MODIFY) ? w_match : w_val;
    end
    if (load_res) begin
      m_axis_tdata <= {res_count, res_pos, res_data, res_status};
    end
  end

endmodule

// ===== verif/doubly_linked_list_engine_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// doubly_linked_list_engine_unit_tb : regression for the ordered list engine
// Drives list commands under random idling and stalls. A shadow list model
// predicts each result beat, and a scoreboard compares the beats in order.
// ----------------------------------------------------------------------------
module doubly_linked_list_engine_unit_tb;
  import dlle_pkg::*;

  localparam int CAP = 64;
  localparam int CYCLE_LIMIT = 1500000;

  // first member lands in the top bits: count, position, data, status
  typedef struct packed {
    logic [6:0]  count;
    logic [6:0]  position;
    logic [31:0] data;
    logic [1:0]  status;
  } list_result_t;

  class list_scoreboard;
    list_result_t pending_q[$];
    int           errors;

    function void note_command(list_result_t r);
      pending_q.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_beat(list_result_t got);
      list_result_t exp;
      if (pending_q.size() == 0) begin
        report("result beat with nothing pending");
      end else begin
        exp = pending_q.pop_front();
        if (got !== exp) begin
          report($sformatf("got st %0d d %h p %0d c %0d, want st %0d d %h p %0d c %0d",
                           got.status, got.data, got.position, got.count,
                           exp.status, exp.data, exp.position, exp.count));
        end
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata;  // op index value match_value
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;  // status data position count

  doubly_linked_list_engine_unit dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  list_scoreboard sb;
  // shadow list: plain ordered array of entries
  logic [31:0] shadow_list[$];
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_off = 0;
  int          cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic list_result_t predict_list(logic [3:0] op, logic [5:0] idx,
                                                logic [31:0] val, logic [31:0] oldv);
    list_result_t r;
    int           hit;
    r = '0;
    hit = -1;
    case (op)
      OP_HEAD_ADD: begin
        if (shadow_list.size() >= CAP) r.status = ST_FULL;
        else shadow_list.push_front(val);
      end
      OP_TAIL_ADD: begin
        if (shadow_list.size() >= CAP) r.status = ST_FULL;
        else shadow_list.push_back(val);
      end
      OP_INSERT_AT: begin
        if (idx >= shadow_list.size()) r.status = ST_RANGE;
        else if (shadow_list.size() >= CAP) r.status = ST_FULL;
        else shadow_list.insert(idx, val);
      end
      OP_HEAD_DEL: begin
        if (shadow_list.size() == 0) r.status = ST_RANGE;
        else void'(shadow_list.pop_front());
      end
      OP_TAIL_DEL: begin
        if (shadow_list.size() == 0) r.status = ST_RANGE;
        else void'(shadow_list.pop_back());
      end
      OP_DEL_AT: begin
        if (idx >= shadow_list.size()) r.status = ST_RANGE;
        else shadow_list.delete(idx);
      end
      OP_READ_AT: begin
        if (idx >= shadow_list.size()) r.status = ST_RANGE;
        else r.data = shadow_list[idx];
      end
      OP_MODIFY, OP_FIND, OP_DEL_VALUE: begin
        for (int i = 0; i < shadow_list.size(); i++)
          if (hit < 0 && shadow_list[i] == ((op == OP_MODIFY) ? oldv : val)) hit = i;
        if (hit < 0) r.status = ST_MISS;
        else if (op == OP_MODIFY) shadow_list[hit] = val;
        else if (op == OP_FIND) r.position = 7'(hit);
        else shadow_list.delete(hit);
      end
      OP_CLEAR: shadow_list.delete();
      default: ;
    endcase
    r.count = 7'(shadow_list.size());
    return r;
  endfunction

  task automatic send_command(logic [3:0] op, logic [5:0] idx, logic [31:0] val,
                              logic [31:0] oldv);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tdata  <= {6'd0, oldv, val, idx, op};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_command(predict_list(op, idx, val, oldv));
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    int sel;
    sel = $urandom_range(9);
    if (sel < 5 && shadow_list.size() > 0)
      return shadow_list[$urandom_range(shadow_list.size() - 1)];
    if (sel < 8) return $urandom_range(7);
    return $urandom;
  endfunction

  task automatic random_command();
    logic [3:0] op;
    logic [5:0] idx;
    int         w;
    w = $urandom_range(99);
    if (w < 2) op = 4'($urandom_range(15));
    else if (w < 4) op = OP_CLEAR;
    else op = 4'($urandom_range(9));
    if (shadow_list.size() > 40 && $urandom_range(1)) op = 4'($urandom_range(3, 5));
    if (shadow_list.size() > 0 && $urandom_range(4) != 0)
      idx = 6'($urandom_range(shadow_list.size() - 1));
    else idx = 6'($urandom);
    send_command(op, idx, pick_value(), pick_value());
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
  endtask

  // receiver
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_beat(m_axis_tdata);
  end

  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_off <= 300;
      m_axis_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("doubly_linked_list_engine_unit regression: fail");
      $finish;
    end
  end

  initial begin
    sb = new();
    sb.errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty list corner cases, extremes, full list
    send_command(OP_HEAD_DEL, 0, 0, 0);
    send_command(OP_TAIL_DEL, 0, 0, 0);
    send_command(OP_READ_AT, 6'h3f, 0, 0);
    send_command(OP_FIND, 0, 32'h8000_0000, 0);
    send_command(OP_HEAD_ADD, 0, 32'h8000_0000, 0);
    send_command(OP_TAIL_ADD, 6'h3f, 32'h7fff_ffff, 32'hffff_ffff);
    send_command(OP_INSERT_AT, 1, 32'hffff_ffff, 0);
    send_command(OP_INSERT_AT, 3, 5, 0);
    send_command(OP_READ_AT, 1, 0, 0);
    send_command(OP_FIND, 0, 32'h7fff_ffff, 0);
    send_command(OP_MODIFY, 0, 9, 32'hffff_ffff);
    send_command(OP_MODIFY, 0, 9, 32'h1234);
    send_command(OP_DEL_VALUE, 0, 32'h8000_0000, 0);
    send_command(OP_DEL_VALUE, 0, 32'h5555, 0);
    send_command(OP_DEL_AT, 1, 0, 0);
    send_command(4'd15, 6'h2a, 32'haaaa_aaaa, 32'h5555_5555);
    for (int i = 0; i < 65; i++) send_command(OP_TAIL_ADD, 0, i, 0);
    send_command(OP_INSERT_AT, 0, 1, 0);
    send_command(OP_HEAD_ADD, 0, 1, 0);
    send_command(OP_READ_AT, 6'h3f, 0, 0);
    send_command(OP_DEL_AT, 6'h3f, 0, 0);
    send_command(OP_FIND, 0, 62, 0);
    send_command(OP_CLEAR, 0, 0, 0);
    wait_drained();

    // long receiver hold-off while the sender keeps offering
    hold_req = hold_req + 1;
    for (int i = 0; i < 20; i++) random_command();
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 75 : (ph == 3) ? 36 : 0;
      recv_stall_pct = (ph == 2) ? 75 : (ph == 3) ? 36 : 0;
      for (int i = 0; i < 200; i++) random_command();
      wait_drained();
    end

    repeat (100) @(negedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("doubly_linked_list_engine_unit regression: pass");
    end else begin
      $display("doubly_linked_list_engine_unit regression: fail");
    end
    $finish;
  end
endmodule
